>>> rtl/integer_matrix_multiply_assert.svh
// assertion macros for the integer matrix multiplier
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication, off during reset
`define IMM_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("integer_matrix_multiply: assertion failed");

// next-cycle implication, off during reset
`define IMM_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("integer_matrix_multiply: assertion failed");

`endif

>>> rtl/imm_pkg.sv
// shared types, widths and codes of the integer matrix multiplier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;
    localparam int DIM_W    = 4;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START       = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIM_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COUNT_BAD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLS = 2'd3;

    typedef logic [DIM_W-1:0] t_dim;

    // zero reads as one, anything above the limit reads as the limit
    function automatic t_dim clamp_dim(t_dim v, t_dim max_dim);
        t_dim r;
        if (v == '0) begin
            r = t_dim'(1);
        end else if (v > max_dim) begin
            r = max_dim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/imm_item_if.sv
// input channel of the integer matrix multiplier: action and element
// depends on imm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface imm_item_if;
    logic                                valid;
    logic                                ready;
    logic [imm_pkg::ACTION_W-1:0]        action;
    logic signed [imm_pkg::VALUE_W-1:0]  element;

    modport source (output valid, output action, output element, input ready);
    modport sink   (input valid, input action, input element, output ready);
endinterface

`default_nettype wire

>>> rtl/imm_result_if.sv
// result channel of the integer matrix multiplier
// depends on imm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface imm_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [imm_pkg::VALUE_W-1:0]  product_value;
    logic [imm_pkg::POS_W-1:0]           out_row;
    logic [imm_pkg::POS_W-1:0]           out_col;
    logic [imm_pkg::STATUS_W-1:0]        status;
    logic                                last;

    modport source (output valid, output product_value, output out_row, output out_col,
                    output status, output last, input ready);
    modport sink   (input valid, input product_value, input out_row, input out_col,
                    input status, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/imm_store.sv
// matrix element store: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module imm_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/integer_matrix_multiply.sv
// integer matrix multiplier top level: load, count and shape check, shared multiply-accumulate
// depends on imm_pkg, imm_item_if, imm_result_if, imm_store and the assertion header
//
//  channel    dir  handshake      payload
//  i_item     in   valid/ready    action, element
//  o_result   out  valid/ready    product_value, out_row, out_col, status, last
//  i_cfg_*    in   write enable   i_cfg_index, i_cfg_data
//
// loads and idle actions may arrive back to back; items are accepted only in the idle state
// a start does one store read and one multiplier pass per inner step of each entry,
//   then drains the mac pipeline before the entry is emitted
// a status-only start goes through the status state; a stalled result output holds the sequencer
// reset is synchronous: counters and control clear, shape registers go to 8, stores do not
`timescale 1ns / 1ps
`default_nettype none

`include "integer_matrix_multiply_assert.svh"

module integer_matrix_multiply #(
    parameter int MAX_DIM       = 8,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    imm_item_if.sink                             i_item,
    imm_result_if.source                         o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [imm_pkg::DIM_W-1:0]       i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VW     = imm_pkg::VALUE_W;
    localparam int CW     = imm_pkg::COUNT_W;
    localparam int NEED_W = 2 * imm_pkg::DIM_W;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_STATUS} t_state;

    t_state r_state;

    imm_pkg::t_dim r_first_rows, r_first_cols, r_second_rows, r_second_cols;
    logic [CW-1:0] r_first_count, r_second_count;

    // working shape of the product a x b
    imm_pkg::t_dim r_ar, r_ac, r_bc;
    logic          r_swap;
    logic [IDX_W-1:0]  r_i, r_j, r_k;
    logic [ADDR_W-1:0] r_a_base, r_a_addr, r_b_addr;
    logic [imm_pkg::STATUS_W-1:0] r_status;

    // mac pipeline
    logic          r_v1, r_last1, r_v2, r_last2, r_done;
    logic [VW-1:0] r_prod, r_acc;

    logic                          r_out_valid;
    logic [VW-1:0]                 r_out_value;
    logic [imm_pkg::POS_W-1:0]     r_out_row, r_out_col;
    logic [imm_pkg::STATUS_W-1:0]  r_out_status;
    logic                          r_out_last;

    imm_pkg::t_dim c_fr, c_fc, c_sr, c_sc;
    logic [NEED_W-1:0] first_need, second_need;
    logic counts_ok;
    logic in_acc, out_free, issue_last, col_last, entry_last, emit, load_out;
    logic [ADDR_W-1:0] n_a_base;

    logic first_we, second_we, rd_en;
    logic [ADDR_W-1:0] first_rd_addr, second_rd_addr;
    logic [ELEMENT_WIDTH-1:0] first_q, second_q;
    logic [VW-1:0] a_ext, b_ext;

    assign c_fr = imm_pkg::clamp_dim(r_first_rows,  imm_pkg::t_dim'(MAX_DIM));
    assign c_fc = imm_pkg::clamp_dim(r_first_cols,  imm_pkg::t_dim'(MAX_DIM));
    assign c_sr = imm_pkg::clamp_dim(r_second_rows, imm_pkg::t_dim'(MAX_DIM));
    assign c_sc = imm_pkg::clamp_dim(r_second_cols, imm_pkg::t_dim'(MAX_DIM));

    assign first_need  = NEED_W'(c_fr) * NEED_W'(c_fc);
    assign second_need = NEED_W'(c_sr) * NEED_W'(c_sc);
    assign counts_ok = ({1'b0, r_first_count} == first_need) &&
                       ({1'b0, r_second_count} == second_need);

    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;

    assign issue_last = (imm_pkg::t_dim'(r_k) + imm_pkg::t_dim'(1)) == r_ac;
    assign col_last   = (imm_pkg::t_dim'(r_j) + imm_pkg::t_dim'(1)) == r_bc;
    assign entry_last = col_last &&
                        ((imm_pkg::t_dim'(r_i) + imm_pkg::t_dim'(1)) == r_ar);
    assign emit     = (r_state == S_DRAIN) && r_done && out_free;
    assign load_out = emit || ((r_state == S_STATUS) && out_free);
    assign n_a_base = ADDR_W'(r_a_base + ADDR_W'(r_ac));

    // store ports
    assign first_we  = in_acc && (i_item.action == imm_pkg::ACT_LOAD_FIRST) &&
                       (r_first_count < CW'(DEPTH));
    assign second_we = in_acc && (i_item.action == imm_pkg::ACT_LOAD_SECOND) &&
                       (r_second_count < CW'(DEPTH));
    assign rd_en = (r_state == S_ISSUE);
    assign first_rd_addr  = r_swap ? r_b_addr : r_a_addr;
    assign second_rd_addr = r_swap ? r_a_addr : r_b_addr;

    imm_store #(.DEPTH(DEPTH), .WIDTH(ELEMENT_WIDTH)) u_first_store (
        .i_clk     (i_clk),
        .i_we      (first_we),
        .i_wr_addr (r_first_count[ADDR_W-1:0]),
        .i_wr_data (i_item.element[ELEMENT_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (first_rd_addr),
        .o_rd_data (first_q)
    );

    imm_store #(.DEPTH(DEPTH), .WIDTH(ELEMENT_WIDTH)) u_second_store (
        .i_clk     (i_clk),
        .i_we      (second_we),
        .i_wr_addr (r_second_count[ADDR_W-1:0]),
        .i_wr_data (i_item.element[ELEMENT_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (second_rd_addr),
        .o_rd_data (second_q)
    );

    // stores keep the narrow element, sign extension happens on the way out
    assign a_ext = r_swap ? VW'(signed'(second_q)) : VW'(signed'(first_q));
    assign b_ext = r_swap ? VW'(signed'(first_q))  : VW'(signed'(second_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_first_rows   <= imm_pkg::t_dim'(8);
            r_first_cols   <= imm_pkg::t_dim'(8);
            r_second_rows  <= imm_pkg::t_dim'(8);
            r_second_cols  <= imm_pkg::t_dim'(8);
            r_first_count  <= '0;
            r_second_count <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_done         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_acc          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    imm_pkg::CFG_FIRST_ROWS:  r_first_rows  <= i_cfg_data;
                    imm_pkg::CFG_FIRST_COLS:  r_first_cols  <= i_cfg_data;
                    imm_pkg::CFG_SECOND_ROWS: r_second_rows <= i_cfg_data;
                    imm_pkg::CFG_SECOND_COLS: r_second_cols <= i_cfg_data;
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            // mac pipeline: read, multiply, accumulate
            r_v1    <= rd_en;
            r_last1 <= issue_last;
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            r_prod  <= a_ext * b_ext;
            if (r_v2) begin
                r_acc <= r_acc + r_prod;
                if (r_last2) begin
                    r_done <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_item.action)
                            imm_pkg::ACT_LOAD_FIRST: begin
                                if (r_first_count < imm_pkg::COUNT_MAX) begin
                                    r_first_count <= r_first_count + CW'(1);
                                end
                            end
                            imm_pkg::ACT_LOAD_SECOND: begin
                                if (r_second_count < imm_pkg::COUNT_MAX) begin
                                    r_second_count <= r_second_count + CW'(1);
                                end
                            end
                            imm_pkg::ACT_START: begin
                                r_first_count  <= '0;
                                r_second_count <= '0;
                                r_i      <= '0;
                                r_j      <= '0;
                                r_k      <= '0;
                                r_a_base <= '0;
                                r_a_addr <= '0;
                                r_b_addr <= '0;
                                r_acc    <= '0;
                                if (!counts_ok) begin
                                    r_status <= imm_pkg::ST_COUNT_BAD;
                                    r_state  <= S_STATUS;
                                end else if (c_fc == c_sr) begin
                                    r_swap  <= 1'b0;
                                    r_ar    <= c_fr;
                                    r_ac    <= c_fc;
                                    r_bc    <= c_sc;
                                    r_state <= S_ISSUE;
                                end else if (c_fr == c_sc) begin
                                    r_swap  <= 1'b1;
                                    r_ar    <= c_sr;
                                    r_ac    <= c_sc;
                                    r_bc    <= c_fc;
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_status <= imm_pkg::ST_DIM_BAD;
                                    r_state  <= S_STATUS;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ISSUE: begin
                    r_a_addr <= r_a_addr + ADDR_W'(1);
                    r_b_addr <= ADDR_W'(r_b_addr + ADDR_W'(r_bc));
                    if (issue_last) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (emit) begin
                        r_out_value  <= r_acc;
                        r_out_row    <= imm_pkg::POS_W'(r_i);
                        r_out_col    <= imm_pkg::POS_W'(r_j);
                        r_out_status <= imm_pkg::ST_OK;
                        r_out_last   <= entry_last;
                        r_done       <= 1'b0;
                        r_acc        <= '0;
                        if (col_last) begin
                            r_j      <= '0;
                            r_i      <= r_i + IDX_W'(1);
                            r_a_base <= n_a_base;
                            r_a_addr <= n_a_base;
                            r_b_addr <= '0;
                        end else begin
                            r_j      <= r_j + IDX_W'(1);
                            r_a_addr <= r_a_base;
                            r_b_addr <= ADDR_W'(r_j) + ADDR_W'(1);
                        end
                        r_state <= entry_last ? S_IDLE : S_ISSUE;
                    end
                end
                S_STATUS: begin
                    if (out_free) begin
                        r_out_value  <= '0;
                        r_out_row    <= '0;
                        r_out_col    <= '0;
                        r_out_status <= r_status;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.product_value = r_out_value;
    assign o_result.out_row       = r_out_row;
    assign o_result.out_col       = r_out_col;
    assign o_result.status        = r_out_status;
    assign o_result.last          = r_out_last;

    // a status item is always the only and final item of its start
    `IMM_ASSERT_IMP(a_status_is_last, r_out_valid && (r_out_status != imm_pkg::ST_OK), r_out_last && (r_out_value == '0))
    // the mac pipeline only carries work while a product is being formed
    `IMM_ASSERT_IMP(a_pipe_in_compute, r_v1 || r_v2, (r_state == S_ISSUE) || (r_state == S_DRAIN))
    // a finished sum never overlaps in-flight steps
    `IMM_ASSERT_IMP(a_done_drained, r_done, !r_v1 && !r_v2 && (r_state == S_DRAIN))
    // a start always clears both load counters
    `IMM_ASSERT_NXT(a_start_clears, in_acc && (i_item.action == imm_pkg::ACT_START), (r_first_count == '0) && (r_second_count == '0))

endmodule

`default_nettype wire

>>> dv/integer_matrix_multiply_checker.sv
// result checker for the integer matrix multiplier: watches the item, result and shape ports,
// keeps its own copy of both matrices and the shape, and compares every result item in order
// depends on imm_pkg, imm_item_if and imm_result_if
`timescale 1ns / 1ps

module integer_matrix_multiply_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    imm_item_if                             i_item,
    imm_result_if                           i_result,
    input  logic                            i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]       i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import imm_pkg::*;

    localparam int DIM_MAX = 8;
    localparam int DEPTH   = DIM_MAX * DIM_MAX;

    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_product;

    // index 0 holds the first matrix, index 1 the second
    logic [VALUE_W-1:0] loaded_mat [2][DEPTH];
    logic [COUNT_W-1:0] loaded_count [2];
    t_dim               shape_fr, shape_fc, shape_sr, shape_sc;
    t_product           expected_products [$];
    int                 fail_total = 0;

    function automatic int eff_dim(t_dim v);
        if (v == '0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return int'(v);
    endfunction

    function automatic void report_bad(string what, t_product want);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t ns: %s: expected value %0d row %0d col %0d status %0d last %0d",
                     $time, what, $signed(want.value), want.row, want.col, want.status,
                     want.last);
            $display("    got value %0d row %0d col %0d status %0d last %0d",
                     i_result.product_value, i_result.out_row, i_result.out_col,
                     i_result.status, i_result.last);
        end
    endfunction

    // queue one expected result item at the tail
    function automatic void expect_product(t_product p);
        expected_products.insert(expected_products.size(), p);
    endfunction

    // count check first, then first x second, then second x first, else a shape error
    function automatic void predict_products();
        int                 fr, fc, sr, sc, ar, ac, bc;
        bit                 swap;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] lhs, rhs;
        t_product           p;
        fr = eff_dim(shape_fr);
        fc = eff_dim(shape_fc);
        sr = eff_dim(shape_sr);
        sc = eff_dim(shape_sc);
        p = '{default: '0};
        p.last = 1'b1;
        if (int'(loaded_count[0]) != fr * fc || int'(loaded_count[1]) != sr * sc) begin
            p.status = ST_COUNT_BAD;
            expect_product(p);
        end else if (fc != sr && fr != sc) begin
            p.status = ST_DIM_BAD;
            expect_product(p);
        end else begin
            swap = (fc != sr);
            ar = swap ? sr : fr;
            ac = swap ? sc : fc;
            bc = swap ? fc : sc;
            for (int i = 0; i < ar; i++) begin
                for (int j = 0; j < bc; j++) begin
                    acc = '0;
                    for (int k = 0; k < ac; k++) begin
                        lhs = loaded_mat[swap ? 1 : 0][i * ac + k];
                        rhs = loaded_mat[swap ? 0 : 1][k * bc + j];
                        acc = acc + lhs * rhs;
                    end
                    p.value  = acc;
                    p.row    = POS_W'(i);
                    p.col    = POS_W'(j);
                    p.status = ST_OK;
                    p.last   = (i == ar - 1 && j == bc - 1);
                    expect_product(p);
                end
            end
        end
        loaded_count[0] = '0;
        loaded_count[1] = '0;
    endfunction

    always @(posedge i_clk) begin
        t_product want;
        int       which;
        if (!i_rst_n) begin
            loaded_count[0] = '0;
            loaded_count[1] = '0;
            shape_fr = t_dim'(DIM_MAX);
            shape_fc = t_dim'(DIM_MAX);
            shape_sr = t_dim'(DIM_MAX);
            shape_sc = t_dim'(DIM_MAX);
            expected_products.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_products.size() == 0) begin
                    want = '{default: '0};
                    report_bad("result item with none expected", want);
                end else begin
                    want = expected_products.pop_front();
                    if (want.value !== i_result.product_value || want.row !== i_result.out_row
                        || want.col !== i_result.out_col || want.status !== i_result.status
                        || want.last !== i_result.last) begin
                        report_bad("result item mismatch", want);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRST_ROWS:  shape_fr = i_cfg_data;
                    CFG_FIRST_COLS:  shape_fc = i_cfg_data;
                    CFG_SECOND_ROWS: shape_sr = i_cfg_data;
                    CFG_SECOND_COLS: shape_sc = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                case (i_item.action)
                    ACT_LOAD_FIRST, ACT_LOAD_SECOND: begin
                        which = (i_item.action == ACT_LOAD_SECOND) ? 1 : 0;
                        // past capacity the element is dropped, the count saturates
                        if (loaded_count[which] < DEPTH) begin
                            loaded_mat[which][loaded_count[which]] = i_item.element;
                        end
                        if (loaded_count[which] != COUNT_MAX) begin
                            loaded_count[which] = loaded_count[which] + 1'b1;
                        end
                    end
                    ACT_START: predict_products();
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_products.size();
    end

endmodule

>>> dv/integer_matrix_multiply_tb.sv
// testbench top for the integer matrix multiplier: clock, reset, shape writes and item stimulus
// depends on imm_pkg, the channel interfaces, the block and integer_matrix_multiply_checker
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;
    import imm_pkg::*;

    localparam int DIM_MAX       = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 160;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    bit                   steady = 1'b0;
    int                   items_sent = 0;
    int                   random_base;
    int                   fail_count;
    int                   pending;

    imm_item_if   item_ch ();
    imm_result_if result_ch ();

    integer_matrix_multiply #(
        .MAX_DIM       (DIM_MAX),
        .ELEMENT_WIDTH (VALUE_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    integer_matrix_multiply_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item_ch),
        .i_result       (result_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        result_ch.ready <= steady || ($urandom_range(99) >= 9);
    end

    function automatic logic [VALUE_W-1:0] rand_element();
        case ($urandom_range(19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return '0;
            4: return VALUE_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_dim();
        if ($urandom_range(99) < 5) return DIM_MAX;
        return $urandom_range(1, 4);
    endfunction

    // out-of-range register values that read back as the same size
    function automatic t_dim pick_reg(int d);
        if (d == 1 && $urandom_range(2) == 0) return '0;
        if (d == DIM_MAX && $urandom_range(1) == 0) return t_dim'($urandom_range(15, DIM_MAX + 1));
        return t_dim'(d);
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(99) < 9) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= act;
        item_ch.element <= value;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    // hold off the sender until every outstanding product has come out
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shape(input t_dim fr, input t_dim fc, input t_dim sr, input t_dim sc);
        t_dim                 vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        vals = '{fr, fc, sr, sc};
        regs = '{CFG_FIRST_ROWS, CFG_FIRST_COLS, CFG_SECOND_ROWS, CFG_SECOND_COLS};
        wait_idle();
        for (int r = 0; r < 4; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one load sequence and start, sometimes with a count off by one or nothing loaded
    task automatic multiply_once(input int fr, fc, sr, sc);
        int n_first, n_second, kind;
        n_first  = fr * fc;
        n_second = sr * sc;
        kind     = $urandom_range(99);
        if (kind < 8) begin
            n_first = n_first + ($urandom_range(1) ? 1 : -1);
        end else if (kind < 16) begin
            n_second = n_second + ($urandom_range(1) ? 1 : -1);
        end else if (kind < 19) begin
            n_first  = 0;
            n_second = 0;
        end
        while (n_first > 0 || n_second > 0) begin
            if ($urandom_range(99) < 4) send_item(ACT_UNUSED, rand_element());
            if (n_second == 0 || (n_first > 0 && $urandom_range(1) == 1)) begin
                send_item(ACT_LOAD_FIRST, rand_element());
                n_first--;
            end else begin
                send_item(ACT_LOAD_SECOND, rand_element());
                n_second--;
            end
        end
        if ($urandom_range(99) < 10) wait_idle();
        send_item(ACT_START, rand_element());
    endtask

    task automatic run_session();
        int m, n, p, fr, fc, sr, sc, shape;
        m     = pick_dim();
        n     = pick_dim();
        p     = pick_dim();
        shape = $urandom_range(9);
        fr    = m;
        fc    = n;
        if (shape < 6) begin
            sr = n;
            sc = p;
        end else if (shape < 8) begin
            // inner sizes differ, outer ones agree: second times first
            sr = (p == n) ? (n % 4) + 1 : p;
            sc = m;
        end else begin
            sr = pick_dim();
            sc = pick_dim();
        end
        write_shape(pick_reg(fr), pick_reg(fc), pick_reg(sr), pick_reg(sc));
        repeat ($urandom_range(1, 3)) multiply_once(fr, fc, sr, sc);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.action  <= ACT_LOAD_FIRST;
        item_ch.element <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_FIRST_ROWS;
        cfg_data        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start with nothing loaded
        send_item(ACT_START, 32'hFFFF_FFFF);

        // zero-size registers read as 1x1, product wraps
        write_shape(4'd0, 4'd0, 4'd1, 4'd1);
        send_item(ACT_LOAD_FIRST, 32'h7FFF_FFFF);
        send_item(ACT_UNUSED, 32'h1234_5678);
        send_item(ACT_LOAD_SECOND, 32'h8000_0000);
        send_item(ACT_START, '0);

        // no inner size agrees
        write_shape(4'd1, 4'd2, 4'd1, 4'd3);
        send_item(ACT_LOAD_FIRST, '0);
        send_item(ACT_LOAD_FIRST, 32'hFFFF_FFFF);
        send_item(ACT_LOAD_SECOND, 32'h8000_0000);
        send_item(ACT_LOAD_SECOND, 32'h7FFF_FFFF);
        send_item(ACT_LOAD_SECOND, 32'h0000_0001);
        send_item(ACT_START, '0);

        // second times first
        write_shape(4'd1, 4'd2, 4'd3, 4'd1);
        repeat (2) send_item(ACT_LOAD_FIRST, rand_element());
        repeat (3) send_item(ACT_LOAD_SECOND, rand_element());
        send_item(ACT_START, '0);

        write_shape(4'd2, 4'd2, 4'd2, 4'd2);
        send_item(ACT_LOAD_FIRST, 32'hFFFF_FFFF);
        send_item(ACT_LOAD_SECOND, 32'hFFFF_FFFF);
        send_item(ACT_LOAD_FIRST, 32'h7FFF_FFFF);
        send_item(ACT_LOAD_SECOND, 32'hFFFF_FFFF);
        send_item(ACT_LOAD_FIRST, 32'h8000_0000);
        send_item(ACT_LOAD_SECOND, '0);
        send_item(ACT_LOAD_FIRST, 32'h0000_0001);
        send_item(ACT_LOAD_SECOND, 32'h8000_0000);
        send_item(ACT_START, '0);

        // loads past capacity, count saturates well beyond 1x1
        write_shape(4'd1, 4'd1, 4'd15, 4'd0);
        repeat (129) send_item(ACT_LOAD_FIRST, rand_element());
        repeat (8) send_item(ACT_LOAD_SECOND, rand_element());
        send_item(ACT_START, '0);

        // full 8x8 product from an 8x1 and a 1x8
        write_shape(4'd8, 4'd1, 4'd1, 4'd8);
        repeat (8) send_item(ACT_LOAD_FIRST, rand_element());
        repeat (8) send_item(ACT_LOAD_SECOND, rand_element());
        send_item(ACT_START, '0);

        random_base = items_sent;
        for (int s = 0; items_sent - random_base < RANDOM_ITEMS; s++) begin
            steady <= (s >= 3 && s < 6);
            run_session();
        end
        steady <= 1'b0;

        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
